/* sv/controller_event_to_input_ports_top_assert.svh */
// Assertion macros used by the cetip_back module.
`ifndef CONTROLLER_EVENT_TO_INPUT_PORTS_TOP_ASSERT_SVH
`define CONTROLLER_EVENT_TO_INPUT_PORTS_TOP_ASSERT_SVH

// The property must hold in the same cycle as its condition.
`define CETIP_ASSERT_IMPLY(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("cetip assertion failed");

// The property must hold in the cycle after its condition.
`define CETIP_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("cetip assertion failed");

`endif

/* sv/cetip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cetip_pkg;

    localparam logic [1:0] CMD_PRESS   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_HAT     = 2'd2;
    localparam logic [1:0] CMD_AXIS    = 2'd3;

    localparam logic [1:0] SEL_P1 = 2'd1;
    localparam logic [1:0] SEL_P2 = 2'd2;

    localparam logic [3:0] FN_UP    = 4'd0;
    localparam logic [3:0] FN_DOWN  = 4'd1;
    localparam logic [3:0] FN_LEFT  = 4'd2;
    localparam logic [3:0] FN_RIGHT = 4'd3;
    localparam logic [3:0] FN_START = 4'd8;
    localparam logic [3:0] FN_COIN  = 4'd9;
    localparam logic [3:0] FN_MENU  = 4'd10;

    localparam int AXIS_CODES   = 16;
    localparam int SLOT_FIELD_W = 8;
    localparam int AXIS_W       = 17;
    localparam int THRESH_W     = 15;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd10000;
    localparam int QUEUE_DEPTH  = 2;

    typedef logic [SLOT_FIELD_W-1:0] t_slot;
    typedef logic signed [AXIS_W-1:0] t_axis;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PRESS,
        OP_RELEASE,
        OP_HAT,
        OP_AXIS
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  mask;
        logic        who;
        logic [3:0]  fn;
        t_slot       slot;
        t_axis       value;
        logic        v_hi;
        logic        v_lo;
        logic [3:0]  hat;
    } t_op;

endpackage

`default_nettype wire

/* sv/controller_event_to_input_ports_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Turns mapped controller events (press, release, hat, axis) into the active-low player,
// coin and start port bytes plus a menu request, one result transaction per event. One
// event can be accepted every cycle while the output side is ready; it passes the front
// register, queue, execute stage and output register. The rate is set by the execute
// stage, which reads the axis store as an event enters and writes it back in the cycle
// the result is registered, with a bypass when consecutive events touch the same slot.
// The axis store is a RAM with one valid bit per slot, so there is no clearing pass after
// reset. The threshold register must only be written while no transaction is in flight.
module controller_event_to_input_ports_top #(
    parameter int AXIS_SLOTS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [cetip_pkg::THRESH_W-1:0] i_cfg_wr_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_command,
    input  wire logic [1:0]                    i_player_sel,
    input  wire logic [3:0]                    i_button,
    input  wire logic [3:0]                    i_axis_slot,
    input  wire logic signed [15:0]            i_axis_value,
    input  wire logic                          i_axis_inverted,
    input  wire logic [3:0]                    i_hat_bits,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [7:0]                         o_p1_port,
    output logic [7:0]                         o_p2_port,
    output logic [2:0]                         o_coin_port,
    output logic [7:0]                         o_start_port,
    output logic                               o_menu_request
);

    localparam int SLOT_W = (AXIS_SLOTS > 1) ? $clog2(AXIS_SLOTS) : 1;

    logic [cetip_pkg::THRESH_W-1:0] r_threshold;
    logic                           w_fq_valid;
    logic                           w_fq_ready;
    cetip_pkg::t_op                 w_fq_op;
    logic                           w_qb_valid;
    logic                           w_qb_ready;
    cetip_pkg::t_op                 w_qb_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= cetip_pkg::THRESH_RESET;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    cetip_front #(
        .AXIS_SLOTS (AXIS_SLOTS),
        .SLOT_W     (SLOT_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_threshold     (r_threshold),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_command       (i_command),
        .i_player_sel    (i_player_sel),
        .i_button        (i_button),
        .i_axis_slot     (i_axis_slot),
        .i_axis_value    (i_axis_value),
        .i_axis_inverted (i_axis_inverted),
        .i_hat_bits      (i_hat_bits),
        .o_valid         (w_fq_valid),
        .i_ready         (w_fq_ready),
        .o_op            (w_fq_op)
    );

    cetip_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_op    (w_fq_op),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_op     (w_qb_op)
    );

    cetip_back #(
        .AXIS_SLOTS (AXIS_SLOTS),
        .SLOT_W     (SLOT_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_threshold    (r_threshold),
        .i_op_valid     (w_qb_valid),
        .o_op_ready     (w_qb_ready),
        .i_op           (w_qb_op),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_p1_port      (o_p1_port),
        .o_p2_port      (o_p2_port),
        .o_coin_port    (o_coin_port),
        .o_start_port   (o_start_port),
        .o_menu_request (o_menu_request)
    );

endmodule

`default_nettype wire

/* sv/cetip_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module cetip_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/cetip_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module cetip_front #(
    parameter int AXIS_SLOTS = 16,
    parameter int SLOT_W     = (AXIS_SLOTS > 1) ? $clog2(AXIS_SLOTS) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [cetip_pkg::THRESH_W-1:0] i_threshold,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_command,
    input  wire logic [1:0]                    i_player_sel,
    input  wire logic [3:0]                    i_button,
    input  wire logic [3:0]                    i_axis_slot,
    input  wire logic signed [15:0]            i_axis_value,
    input  wire logic                          i_axis_inverted,
    input  wire logic [3:0]                    i_hat_bits,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output cetip_pkg::t_op                     o_op
);

    logic [SLOT_W-1:0] w_slot_lut [cetip_pkg::AXIS_CODES];
    cetip_pkg::t_axis  w_raw;
    cetip_pkg::t_axis  w_v;
    cetip_pkg::t_axis  w_th;
    cetip_pkg::t_axis  w_neg_th;
    logic              w_one_player;
    cetip_pkg::t_op    n_op;
    cetip_pkg::t_op    r_op;
    logic              r_valid;

    for (genvar g = 0; g < cetip_pkg::AXIS_CODES; g++) begin : g_slot
        assign w_slot_lut[g] = SLOT_W'(g % AXIS_SLOTS);
    end

    assign w_raw    = {i_axis_value[15], i_axis_value};
    assign w_v      = i_axis_inverted ? -w_raw : w_raw;
    assign w_th     = {2'b00, i_threshold};
    assign w_neg_th = -w_th;

    assign w_one_player = (i_player_sel == cetip_pkg::SEL_P1) ||
                          (i_player_sel == cetip_pkg::SEL_P2);

    always_comb begin
        n_op.kind  = cetip_pkg::OP_NOP;
        n_op.mask  = i_player_sel;
        n_op.who   = i_player_sel[1];
        n_op.fn    = i_button;
        n_op.slot  = cetip_pkg::t_slot'(w_slot_lut[i_axis_slot]);
        n_op.value = w_v;
        n_op.v_hi  = w_v > w_th;
        n_op.v_lo  = w_v < w_neg_th;
        n_op.hat   = i_hat_bits;
        unique case (i_command)
            cetip_pkg::CMD_PRESS: begin
                n_op.kind = cetip_pkg::OP_PRESS;
            end
            cetip_pkg::CMD_RELEASE: begin
                n_op.kind = cetip_pkg::OP_RELEASE;
            end
            cetip_pkg::CMD_HAT: begin
                if (w_one_player && i_button == cetip_pkg::FN_UP) begin
                    n_op.kind = cetip_pkg::OP_HAT;
                end
            end
            cetip_pkg::CMD_AXIS: begin
                if (w_one_player) begin
                    n_op.kind = cetip_pkg::OP_AXIS;
                end
            end
            default: begin
                n_op.kind = cetip_pkg::OP_NOP;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op <= n_op;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;

endmodule

`default_nettype wire

/* sv/cetip_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module cetip_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire cetip_pkg::t_op i_push_op,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready,
    output cetip_pkg::t_op      o_pop_op
);

    localparam int DEPTH = cetip_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    cetip_pkg::t_op   r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_op     = r_entry[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_push_op;
        end
    end

endmodule

`default_nettype wire

/* sv/cetip_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "controller_event_to_input_ports_top_assert.svh"

module cetip_back #(
    parameter int AXIS_SLOTS = 16,
    parameter int SLOT_W     = (AXIS_SLOTS > 1) ? $clog2(AXIS_SLOTS) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [cetip_pkg::THRESH_W-1:0] i_threshold,
    input  wire logic                          i_op_valid,
    output logic                               o_op_ready,
    input  wire cetip_pkg::t_op                i_op,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [7:0]                         o_p1_port,
    output logic [7:0]                         o_p2_port,
    output logic [2:0]                         o_coin_port,
    output logic [7:0]                         o_start_port,
    output logic                               o_menu_request
);

    function automatic logic [7:0] port_of(input logic [15:0] h);
        logic [7:0] p;
        p[0]   = !(h[cetip_pkg::FN_UP] && !h[cetip_pkg::FN_DOWN]);
        p[1]   = !(h[cetip_pkg::FN_DOWN] && !h[cetip_pkg::FN_UP]);
        p[2]   = !(h[cetip_pkg::FN_LEFT] && !h[cetip_pkg::FN_RIGHT]);
        p[3]   = !(h[cetip_pkg::FN_RIGHT] && !h[cetip_pkg::FN_LEFT]);
        p[7:4] = ~h[7:4];
        return p;
    endfunction

    cetip_pkg::t_op    r_op;
    logic              r_b_valid;
    logic              r_fwd_hit;
    cetip_pkg::t_axis  r_fwd_data;
    logic              r_old_valid;
    logic [AXIS_SLOTS-1:0] r_slot_valid;
    logic [15:0]       r_held0;
    logic [15:0]       r_held1;
    logic [15:0]       n_held0;
    logic [15:0]       n_held1;
    logic              r_out_valid;
    logic [7:0]        r_p1_port;
    logic [7:0]        r_p2_port;
    logic [2:0]        r_coin_port;
    logic [7:0]        r_start_port;
    logic              r_menu_request;

    logic              w_b_adv;
    logic              w_pop;
    logic              w_ram_we;
    logic [SLOT_W-1:0] w_waddr;
    logic [SLOT_W-1:0] w_raddr;
    cetip_pkg::t_axis  w_rdata;
    cetip_pkg::t_axis  w_old;
    cetip_pkg::t_axis  w_th;
    cetip_pkg::t_axis  w_neg_th;
    logic              w_old_hi;
    logic              w_old_lo;
    logic              w_in_band;
    logic              w_set_pos;
    logic              w_clr_pos;
    logic              w_set_neg;
    logic              w_clr_neg;
    logic [3:0]        w_pos;
    logic [3:0]        w_neg;
    logic [15:0]       w_upd;

    assign w_b_adv    = r_b_valid && (!r_out_valid || i_out_ready);
    assign o_op_ready = !r_b_valid || w_b_adv;
    assign w_pop      = i_op_valid && o_op_ready;
    assign w_ram_we   = w_b_adv && r_op.kind == cetip_pkg::OP_AXIS;
    assign w_waddr    = r_op.slot[SLOT_W-1:0];
    assign w_raddr    = i_op.slot[SLOT_W-1:0];

    cetip_ram #(
        .WIDTH (cetip_pkg::AXIS_W),
        .DEPTH (AXIS_SLOTS),
        .AW    (SLOT_W)
    ) u_axis_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (r_op.value),
        .i_re    (w_pop),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid    <= 1'b0;
            r_slot_valid <= '0;
        end else begin
            if (o_op_ready) begin
                r_b_valid <= i_op_valid;
            end
            if (w_ram_we) begin
                r_slot_valid[w_waddr] <= 1'b1;
            end
        end
    end

    // A read issued in the same cycle as a write to the same slot sees the old
    // contents, so the written value is carried along with the transaction.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_op        <= i_op;
            r_fwd_hit   <= w_ram_we && (w_waddr == w_raddr);
            r_fwd_data  <= r_op.value;
            r_old_valid <= r_slot_valid[w_raddr];
        end
    end

    assign w_old     = r_fwd_hit ? r_fwd_data : (r_old_valid ? w_rdata : '0);
    assign w_th      = {2'b00, i_threshold};
    assign w_neg_th  = -w_th;
    assign w_old_hi  = w_old > w_th;
    assign w_old_lo  = w_old < w_neg_th;
    assign w_in_band = !r_op.v_hi && !r_op.v_lo;
    assign w_set_pos = r_op.v_hi;
    assign w_set_neg = r_op.v_lo;
    assign w_clr_pos = r_op.v_lo || (w_old_hi && w_in_band);
    assign w_clr_neg = r_op.v_hi || (w_old_lo && w_in_band);
    assign w_pos     = r_op.fn[1] ? cetip_pkg::FN_RIGHT : cetip_pkg::FN_UP;
    assign w_neg     = r_op.fn[1] ? cetip_pkg::FN_LEFT : cetip_pkg::FN_DOWN;

    always_comb begin
        n_held0 = r_held0;
        n_held1 = r_held1;
        w_upd   = r_op.who ? r_held1 : r_held0;
        if (r_op.kind == cetip_pkg::OP_HAT) begin
            w_upd[3:0] = {r_op.hat[1], r_op.hat[3], r_op.hat[2], r_op.hat[0]};
        end else if (r_op.fn[3:2] == 2'b00) begin
            w_upd[w_pos] = (w_upd[w_pos] || w_set_pos) && !w_clr_pos;
            w_upd[w_neg] = (w_upd[w_neg] || w_set_neg) && !w_clr_neg;
        end
        unique case (r_op.kind) inside
            cetip_pkg::OP_PRESS: begin
                if (r_op.mask[0]) begin
                    n_held0[r_op.fn] = 1'b1;
                end
                if (r_op.mask[1]) begin
                    n_held1[r_op.fn] = 1'b1;
                end
            end
            cetip_pkg::OP_RELEASE: begin
                if (r_op.mask[0]) begin
                    n_held0[r_op.fn] = 1'b0;
                end
                if (r_op.mask[1]) begin
                    n_held1[r_op.fn] = 1'b0;
                end
            end
            cetip_pkg::OP_HAT, cetip_pkg::OP_AXIS: begin
                if (r_op.who) begin
                    n_held1 = w_upd;
                end else begin
                    n_held0 = w_upd;
                end
            end
            default: begin
                n_held0 = r_held0;
                n_held1 = r_held1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held0     <= '0;
            r_held1     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_b_adv) begin
                r_held0     <= n_held0;
                r_held1     <= n_held1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_adv) begin
            r_p1_port      <= port_of(n_held0);
            r_p2_port      <= port_of(n_held1);
            r_coin_port    <= {1'b1, !n_held1[cetip_pkg::FN_COIN],
                               !n_held0[cetip_pkg::FN_COIN]};
            r_start_port   <= {4'b1000, 1'b1, !n_held1[cetip_pkg::FN_START],
                               1'b1, !n_held0[cetip_pkg::FN_START]};
            r_menu_request <= n_held0[cetip_pkg::FN_MENU];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_p1_port      = r_p1_port;
    assign o_p2_port      = r_p2_port;
    assign o_coin_port    = r_coin_port;
    assign o_start_port   = r_start_port;
    assign o_menu_request = r_menu_request;

    `CETIP_ASSERT_NEXT(a_press_sets_bit, i_clk, i_rst_n,
        w_b_adv && r_op.kind == cetip_pkg::OP_PRESS && r_op.mask[0],
        r_held0[$past(r_op.fn)])
    `CETIP_ASSERT_NEXT(a_axis_marks_slot, i_clk, i_rst_n, w_ram_we,
        r_slot_valid[$past(w_waddr)])
    `CETIP_ASSERT_IMPLY(a_opposites_cancel, i_clk, i_rst_n, r_out_valid,
        (r_p1_port[0] || r_p1_port[1]) && (r_p1_port[2] || r_p1_port[3]) &&
        (r_p2_port[0] || r_p2_port[1]) && (r_p2_port[2] || r_p2_port[3]))

endmodule

`default_nettype wire
